/* sv/cttk_pkg.sv */
// Shared types and constants of the configuration text tokenizer.
// Depends on nothing; used by every module of the block.
package cttk_pkg;

    // Token kind codes carried on the result channel.
    localparam logic [2:0] KIND_STRING = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_OPER   = 3'd3;
    localparam logic [2:0] KIND_PUNCT  = 3'd4;
    localparam logic [2:0] KIND_BADCH  = 3'd5;
    localparam logic [2:0] KIND_UNTERM = 3'd6;
    localparam logic [2:0] KIND_END    = 3'd7;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // Number of result slots in the output queue; a byte causes at most two.
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       token_done;
        logic       last;
    } t_result;

    // Results caused by one byte: count 0..2, entries in output order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_lex_out;

endpackage

/* sv/config_text_tokenizer.sv */
// Top level of the configuration text tokenizer.
// Depends on cttk_pkg, cttk_lex and cttk_outq.
//
// Input channel: one text byte per beat on i_ch (i_valid / o_ready);
// a zero byte marks end of input. Output channel: one result per beat
// (o_valid / i_ready) with token kind, optional content byte, token-done
// and last flags; last marks the final result caused by a byte.
// A byte is held in an input register, classified there against the
// lexer mode, and its zero, one or two results go into a two-entry
// result queue that drives the output ports.
// A byte's results pass through the input register and then the result
// queue before they reach the output ports; a full queue holds the byte.
// Throughput: one byte per cycle while each byte causes at most one
// result and the receiver keeps up; a byte that causes two results
// needs a beat for each, as the single result port drains the queue.
// Reset clears the lexer mode to idle and empties both registers.
// When the receiver stalls, the queue fills and o_ready drops once the
// held byte's results no longer fit; nothing is lost.
module config_text_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_byte_value,
    output logic       o_byte_valid,
    output logic       o_token_done,
    output logic       o_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_ch;
    logic               take;
    logic [1:0]         free;
    cttk_pkg::t_lex_out lex;
    cttk_pkg::t_result  res;

    cttk_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ch    (r_in_ch),
        .i_take  (take),
        .o_lex   (lex)
    );

    // The held byte moves on only when all of its results fit the queue.
    assign take    = r_in_valid && (lex.cnt <= free);
    assign o_ready = !r_in_valid || take;

    cttk_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (lex),
        .i_push_cnt  (take ? lex.cnt : 2'd0),
        .i_pop_ready (i_ready),
        .o_valid     (o_valid),
        .o_res       (res),
        .o_free      (free)
    );

    assign o_token_kind = res.token_kind;
    assign o_byte_value = res.byte_value;
    assign o_byte_valid = res.byte_valid;
    assign o_token_done = res.token_done;
    assign o_last       = res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_ch <= i_ch;
        end
    end

endmodule

/* sv/cttk_lex.sv */
// Byte classifier and lexer mode register of the tokenizer.
// Depends on cttk_pkg for result types, kind codes and characters.
module cttk_lex (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_ch,
    input  logic               i_take,
    output cttk_pkg::t_lex_out o_lex
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_STR   = 3'd1,
        MODE_IDENT = 3'd2,
        MODE_NUM   = 3'd3,
        MODE_HALT  = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic              has;
        cttk_pkg::t_result res;
    } t_idle;

    t_mode r_mode;
    t_mode n_mode;

    function automatic cttk_pkg::t_result mk_res(input logic [2:0] kind,
                                                 input logic [7:0] bval,
                                                 input logic       bvalid,
                                                 input logic       done);
        cttk_pkg::t_result r;
        r.token_kind = kind;
        r.byte_value = bvalid ? bval : 8'h00;
        r.byte_valid = bvalid;
        r.token_done = done;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == cttk_pkg::CH_COMMA || c == cttk_pkg::CH_LBRACK ||
               c == cttk_pkg::CH_RBRACK || c == cttk_pkg::CH_LBRACE ||
               c == cttk_pkg::CH_RBRACE;
    endfunction

    // Handling of a byte seen outside any token.
    function automatic t_idle idle_step(input logic [7:0] c);
        t_idle s;
        s.mode = MODE_IDLE;
        s.has  = 1'b1;
        s.res  = mk_res(cttk_pkg::KIND_BADCH, c, 1'b1, 1'b1);
        if (c == cttk_pkg::CH_NUL) begin
            s.res = mk_res(cttk_pkg::KIND_END, c, 1'b0, 1'b1);
        end else if (is_space(c)) begin
            s.has = 1'b0;
        end else if (c == cttk_pkg::CH_QUOTE) begin
            s.mode = MODE_STR;
            s.has  = 1'b0;
        end else if (is_alpha(c)) begin
            s.mode = MODE_IDENT;
            s.res  = mk_res(cttk_pkg::KIND_IDENT, c, 1'b1, 1'b0);
        end else if (is_digit(c)) begin
            s.mode = MODE_NUM;
            s.res  = mk_res(cttk_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
        end else if (c == cttk_pkg::CH_EQ) begin
            s.res  = mk_res(cttk_pkg::KIND_OPER, c, 1'b1, 1'b1);
        end else if (is_punct(c)) begin
            s.res  = mk_res(cttk_pkg::KIND_PUNCT, c, 1'b1, 1'b1);
        end else begin
            s.mode = MODE_HALT;
        end
        return s;
    endfunction

    always_comb begin
        t_idle             idl;
        logic              go_idle;
        logic              pre_has;
        cttk_pkg::t_result pre;
        cttk_pkg::t_result second;
        idl     = idle_step(i_ch);
        go_idle = 1'b0;
        pre_has = 1'b0;
        pre     = mk_res(cttk_pkg::KIND_END, i_ch, 1'b0, 1'b1);
        second  = mk_res(cttk_pkg::KIND_END, i_ch, 1'b0, 1'b1);
        n_mode  = r_mode;
        o_lex.cnt = 2'd0;
        unique case (r_mode)
            MODE_HALT: begin
                if (i_ch == cttk_pkg::CH_NUL) begin
                    n_mode    = MODE_IDLE;
                    pre_has   = 1'b1;
                end
            end
            MODE_STR: begin
                if (i_ch == cttk_pkg::CH_NUL) begin
                    // Unterminated string, then the end result.
                    pre      = mk_res(cttk_pkg::KIND_UNTERM, i_ch, 1'b0, 1'b1);
                    pre_has  = 1'b1;
                    go_idle  = 1'b1;
                end else if (i_ch == cttk_pkg::CH_QUOTE) begin
                    pre      = mk_res(cttk_pkg::KIND_STRING, i_ch, 1'b0, 1'b1);
                    pre_has  = 1'b1;
                    n_mode   = MODE_IDLE;
                end else begin
                    pre      = mk_res(cttk_pkg::KIND_STRING, i_ch, 1'b1, 1'b0);
                    pre_has  = 1'b1;
                end
            end
            MODE_IDENT: begin
                pre_has = 1'b1;
                if (is_alpha(i_ch) || is_digit(i_ch) || i_ch == cttk_pkg::CH_USCORE) begin
                    pre     = mk_res(cttk_pkg::KIND_IDENT, i_ch, 1'b1, 1'b0);
                end else begin
                    pre     = mk_res(cttk_pkg::KIND_IDENT, i_ch, 1'b0, 1'b1);
                    go_idle = 1'b1;
                end
            end
            MODE_NUM: begin
                pre_has = 1'b1;
                if (is_digit(i_ch)) begin
                    pre     = mk_res(cttk_pkg::KIND_NUMBER, i_ch, 1'b1, 1'b0);
                end else begin
                    pre     = mk_res(cttk_pkg::KIND_NUMBER, i_ch, 1'b0, 1'b1);
                    go_idle = 1'b1;
                end
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase

        if (go_idle) begin
            n_mode = idl.mode;
        end

        // Pack the prefix result and the idle result in output order.
        if (pre_has && go_idle && idl.has) begin
            o_lex.cnt = 2'd2;
            o_lex.res0 = pre;
            second     = idl.res;
        end else if (pre_has) begin
            o_lex.cnt = 2'd1;
            o_lex.res0 = pre;
        end else if (go_idle && idl.has) begin
            o_lex.cnt = 2'd1;
            o_lex.res0 = idl.res;
        end else begin
            o_lex.res0 = pre;
        end
        o_lex.res0.last = (o_lex.cnt == 2'd1);
        o_lex.res1      = second;
        o_lex.res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_take) begin
            r_mode <= n_mode;
        end
    end

endmodule

/* sv/cttk_outq.sv */
// Two-entry result queue between the lexer and the output channel.
// Depends on cttk_pkg for the result types and the queue depth.
module cttk_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cttk_pkg::t_lex_out i_push,
    input  logic [1:0]         i_push_cnt,
    input  logic               i_pop_ready,
    output logic               o_valid,
    output cttk_pkg::t_result  o_res,
    output logic [1:0]         o_free
);

    cttk_pkg::t_result r_q [2];
    cttk_pkg::t_result n_q [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[0];
    assign pop     = o_valid && i_pop_ready;
    // A slot freed by this cycle's pop can be refilled in the same cycle.
    assign o_free  = cttk_pkg::QUEUE_DEPTH - r_cnt + {1'b0, pop};

    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (i_push_cnt != 2'd0) begin
            if (n_cnt == 2'd0) begin
                n_q[0] = i_push.res0;
                n_q[1] = i_push.res1;
            end else begin
                n_q[1] = i_push.res0;
            end
        end
        n_cnt = n_cnt + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

/* sv/cttk_checker.sv */
// Port-level checks for the configuration text tokenizer.
// Depends on cttk_pkg for kind codes; bound to config_text_tokenizer.
module cttk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_token_kind,
    input logic [7:0] o_byte_value,
    input logic       o_byte_valid,
    input logic       o_token_done,
    input logic       o_last
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind) &&
        $stable(o_byte_value) && $stable(o_byte_valid) && $stable(o_token_done) &&
        $stable(o_last))
        else $error("result changed while stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result present right after reset");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_byte_value == 8'h00)
        else $error("byte value set without a content byte");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == cttk_pkg::KIND_END |->
        o_token_done && o_last && !o_byte_valid)
        else $error("end result malformed");

    a_single_byte_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == cttk_pkg::KIND_OPER ||
        o_token_kind == cttk_pkg::KIND_PUNCT || o_token_kind == cttk_pkg::KIND_BADCH)
        |-> o_byte_valid && o_token_done && o_last)
        else $error("single-byte token malformed");

endmodule

bind config_text_tokenizer cttk_checker u_cttk_checker (.*);
